FILE: rtl/tlbd_pkg.sv
// Package with the shared types, codes and helpers of the type/length block deframer.
package tlbd_pkg;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [1:0] RES_PAYLOAD = 2'd0;
    localparam logic [1:0] RES_EMPTY   = 2'd1;
    localparam logic [1:0] RES_SUMMARY = 2'd2;

    localparam logic [3:0] DIRECT_MIN = 4'd4;
    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    localparam logic [3:0] KIND_ENTRY_A  = 4'd1;
    localparam logic [3:0] KIND_ENTRY_B  = 4'd7;
    localparam logic [3:0] KIND_ENTRY_C  = 4'd10;
    localparam logic [3:0] KIND_ENTRY_D  = 4'd11;
    localparam logic [3:0] KIND_ENTRY_E  = 4'd13;
    localparam logic [3:0] KIND_RESOURCE = 4'd2;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  block_kind;
        logic [7:0]  payload_byte;
        logic        block_done;
        logic [31:0] block_start;
        logic [23:0] entries_seen;
        logic [23:0] resources_seen;
        logic [31:0] first_entry_at;
        logic [31:0] first_resource_at;
        logic [1:0]  found_flags;
        logic        end_status;
    } result_t;

    function automatic logic is_entry_kind(input logic [3:0] kind);
        logic hit;
        hit = 1'b0;
        case (kind) inside
            KIND_ENTRY_A, KIND_ENTRY_B, KIND_ENTRY_C, KIND_ENTRY_D, KIND_ENTRY_E:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: rtl/tlbd_in_if.sv
// Request channel that carries one stream byte or an end-of-stream marker.
interface tlbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       stream_end;

    modport source (output valid, output stream_byte, output stream_end, input ready);
    modport sink (input valid, input stream_byte, input stream_end, output ready);
endinterface

FILE: rtl/tlbd_out_if.sv
// Request channel that carries one deframed result.
interface tlbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  block_kind;
    logic [7:0]  payload_byte;
    logic        block_done;
    logic [31:0] block_start;
    logic [23:0] entries_seen;
    logic [23:0] resources_seen;
    logic [31:0] first_entry_at;
    logic [31:0] first_resource_at;
    logic [1:0]  found_flags;
    logic        end_status;

    modport source (
        output valid, input ready,
        output result_kind, output block_kind, output payload_byte, output block_done,
        output block_start, output entries_seen, output resources_seen,
        output first_entry_at, output first_resource_at, output found_flags,
        output end_status
    );
    modport sink (
        input valid, output ready,
        input result_kind, input block_kind, input payload_byte, input block_done,
        input block_start, input entries_seen, input resources_seen,
        input first_entry_at, input first_resource_at, input found_flags,
        input end_status
    );
endinterface

FILE: rtl/tlbd_parser.sv
// Block parser: phase, length and offset state, block statistics and result forming.
module tlbd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         stream_byte,
    input  logic               stream_end,
    output logic               res_valid,
    output tlbd_pkg::result_t  res
);

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] pay_left_reg, pay_left_next;
    logic [3:0]  kind_reg, kind_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    logic [23:0] entry_total_reg, entry_total_next;
    logic [23:0] res_total_reg, res_total_next;
    logic [31:0] entry_at_reg, entry_at_next;
    logic        entry_found_reg, entry_found_next;
    logic [31:0] res_at_reg, res_at_next;
    logic        res_found_reg, res_found_next;

    logic        complete;
    logic        emit;
    logic [1:0]  emit_kind;
    logic        emit_done;
    logic [3:0]  code;
    logic [2:0]  len_dec;
    logic [31:0] pay_shift;
    logic [31:0] pay_dec;

    always_comb
    begin
        phase_next       = phase_reg;
        len_left_next    = len_left_reg;
        pay_left_next    = pay_left_reg;
        kind_next        = kind_reg;
        pos_next         = pos_reg;
        start_next       = start_reg;
        entry_total_next = entry_total_reg;
        res_total_next   = res_total_reg;
        entry_at_next    = entry_at_reg;
        entry_found_next = entry_found_reg;
        res_at_next      = res_at_reg;
        res_found_next   = res_found_reg;
        res_valid        = 1'b0;
        res              = '0;
        complete         = 1'b0;
        emit             = 1'b0;
        emit_kind        = tlbd_pkg::RES_PAYLOAD;
        emit_done        = 1'b0;
        code             = stream_byte[7:4];
        len_dec          = (len_left_reg != 3'd0) ? (len_left_reg - 3'd1) : 3'd0;
        pay_shift        = {pay_left_reg[23:0], stream_byte};
        pay_dec          = (pay_left_reg != 32'd0) ? (pay_left_reg - 32'd1) : 32'd0;

        if (take)
        begin
            if (stream_end)
            begin
                res_valid             = 1'b1;
                res.result_kind       = tlbd_pkg::RES_SUMMARY;
                res.end_status        = (phase_reg != tlbd_pkg::PH_HEADER);
                res.block_kind        = res.end_status ? kind_reg : 4'd0;
                res.block_start       = res.end_status ? start_reg : 32'd0;
                res.entries_seen      = entry_total_reg;
                res.resources_seen    = res_total_reg;
                res.first_entry_at    = entry_at_reg;
                res.first_resource_at = res_at_reg;
                res.found_flags       = {res_found_reg, entry_found_reg};
                phase_next            = tlbd_pkg::PH_HEADER;
                len_left_next         = 3'd0;
                pay_left_next         = 32'd0;
            end
            else
            begin
                pos_next = pos_reg + 32'd1;
                unique case (phase_reg)
                    tlbd_pkg::PH_HEADER:
                    begin
                        kind_next  = stream_byte[3:0];
                        start_next = pos_reg;
                        if (code >= tlbd_pkg::DIRECT_MIN)
                        begin
                            pay_left_next = {28'd0, code - tlbd_pkg::DIRECT_MIN};
                            if (code == tlbd_pkg::DIRECT_MIN)
                            begin
                                emit      = 1'b1;
                                emit_kind = tlbd_pkg::RES_EMPTY;
                                emit_done = 1'b1;
                                complete  = 1'b1;
                            end
                            else
                            begin
                                phase_next = tlbd_pkg::PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            len_left_next = {1'b0, code[1:0]} + 3'd1;
                            pay_left_next = 32'd0;
                            phase_next    = tlbd_pkg::PH_LENGTH;
                        end
                    end
                    tlbd_pkg::PH_LENGTH:
                    begin
                        pay_left_next = pay_shift;
                        len_left_next = len_dec;
                        if (len_dec == 3'd0)
                        begin
                            if (pay_shift == 32'd0)
                            begin
                                emit      = 1'b1;
                                emit_kind = tlbd_pkg::RES_EMPTY;
                                emit_done = 1'b1;
                                complete  = 1'b1;
                            end
                            else
                            begin
                                phase_next = tlbd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    tlbd_pkg::PH_PAYLOAD:
                    begin
                        pay_left_next = pay_dec;
                        emit          = 1'b1;
                        emit_kind     = tlbd_pkg::RES_PAYLOAD;
                        emit_done     = (pay_dec == 32'd0);
                        complete      = (pay_dec == 32'd0);
                    end
                    default:
                    begin
                        phase_next = tlbd_pkg::PH_HEADER;
                    end
                endcase

                if (emit)
                begin
                    res_valid        = 1'b1;
                    res.result_kind  = emit_kind;
                    res.block_kind   = kind_next;
                    res.payload_byte = (emit_kind == tlbd_pkg::RES_PAYLOAD) ? stream_byte : 8'd0;
                    res.block_done   = emit_done;
                    res.block_start  = start_next;
                end

                if (complete)
                begin
                    if (tlbd_pkg::is_entry_kind(kind_next))
                    begin
                        if (entry_total_reg != tlbd_pkg::TOTAL_MAX)
                        begin
                            entry_total_next = entry_total_reg + 24'd1;
                        end
                        if (!entry_found_reg)
                        begin
                            entry_found_next = 1'b1;
                            entry_at_next    = start_next;
                        end
                    end
                    else if (kind_next == tlbd_pkg::KIND_RESOURCE)
                    begin
                        if (res_total_reg != tlbd_pkg::TOTAL_MAX)
                        begin
                            res_total_next = res_total_reg + 24'd1;
                        end
                        if (!res_found_reg)
                        begin
                            res_found_next = 1'b1;
                            res_at_next    = start_next;
                        end
                    end
                    phase_next    = tlbd_pkg::PH_HEADER;
                    len_left_next = 3'd0;
                    pay_left_next = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tlbd_pkg::PH_HEADER;
            len_left_reg    <= 3'd0;
            pay_left_reg    <= 32'd0;
            kind_reg        <= 4'd0;
            pos_reg         <= 32'd0;
            start_reg       <= 32'd0;
            entry_total_reg <= 24'd0;
            res_total_reg   <= 24'd0;
            entry_at_reg    <= 32'd0;
            entry_found_reg <= 1'b0;
            res_at_reg      <= 32'd0;
            res_found_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            len_left_reg    <= len_left_next;
            pay_left_reg    <= pay_left_next;
            kind_reg        <= kind_next;
            pos_reg         <= pos_next;
            start_reg       <= start_next;
            entry_total_reg <= entry_total_next;
            res_total_reg   <= res_total_next;
            entry_at_reg    <= entry_at_next;
            entry_found_reg <= entry_found_next;
            res_at_reg      <= res_at_next;
            res_found_reg   <= res_found_next;
        end
    end

endmodule

FILE: rtl/tlbd_out_stage.sv
// Output register stage that holds one result until the downstream side takes it.
module tlbd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               res_valid,
    input  tlbd_pkg::result_t  res,
    output logic               space,
    tlbd_out_if.source         result
);

    logic              valid_reg, valid_next;
    tlbd_pkg::result_t data_reg;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = res_valid || (valid_reg && !result.ready);
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid             = valid_reg;
    assign result.result_kind       = data_reg.result_kind;
    assign result.block_kind        = data_reg.block_kind;
    assign result.payload_byte      = data_reg.payload_byte;
    assign result.block_done        = data_reg.block_done;
    assign result.block_start       = data_reg.block_start;
    assign result.entries_seen      = data_reg.entries_seen;
    assign result.resources_seen    = data_reg.resources_seen;
    assign result.first_entry_at    = data_reg.first_entry_at;
    assign result.first_resource_at = data_reg.first_resource_at;
    assign result.found_flags       = data_reg.found_flags;
    assign result.end_status        = data_reg.end_status;

endmodule

FILE: rtl/type_length_block_deframer.sv
// Top level of the type/length block deframer.
// The block takes one stream byte or end marker per cycle while the output register has space
// and answers each request with at most one result, registered in the output stage: a payload
// byte, an empty-block marker, or an end summary with the entry and resource counts and first
// offsets. A request is taken in every cycle in which the output register is empty or is being
// read, so throughput is one request per clock, set by the single output register stage.
// Header and length bytes produce no result but the empty-block marker of a payload-less block.
module type_length_block_deframer (
    input  logic       clk,
    input  logic       rst_n,
    tlbd_in_if.sink    stream,
    tlbd_out_if.source result
);

    logic              space;
    logic              take;
    logic              res_valid;
    tlbd_pkg::result_t res;

    assign stream.ready = space;
    assign take         = stream.valid && space;

    tlbd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream.stream_byte),
        .stream_end  (stream.stream_end),
        .res_valid   (res_valid),
        .res         (res)
    );

    tlbd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .result    (result)
    );

endmodule
